[design/pgpc_pkg.sv]
// Shared constants, types and the modular addition helper of the palindromic grid path counter.
package pgpc_pkg;

    localparam int MAX_SIDE = 64;
    localparam int SIDE_W   = $clog2(MAX_SIDE);
    localparam int CELL_AW  = 2 * SIDE_W;
    localparam int PAIR_AW  = 2 * SIDE_W + 1;
    localparam int POS_W    = CELL_AW + 1;
    localparam int CHAR_W   = 8;
    localparam int CFG_W    = 7;
    localparam int CNT_W    = 30;

    localparam logic [CNT_W-1:0] PATH_MOD = CNT_W'(1000000007);

    // Control from the top level to the path counting sequencer.
    typedef struct packed {
        logic              start;
        logic              ack;
        logic [SIDE_W-1:0] last;
    } t_dp_req;

    // Status from the sequencer back to the top level.
    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] count;
    } t_dp_rsp;

    // Sum of two residues, reduced once.
    function automatic logic [CNT_W-1:0] mod_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, PATH_MOD}) begin
            s = s - {1'b0, PATH_MOD};
        end
        return s[CNT_W-1:0];
    endfunction

endpackage

[design/pgpc_ram.sv]
// Generic simple dual port RAM with one write port and a registered read port.
module pgpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/pgpc_ctrl.sv]
// Sequencer that runs the layer by layer pair count over the grid and layer memories.
module pgpc_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pgpc_pkg::t_dp_req             i_req,
    output pgpc_pkg::t_dp_rsp             o_rsp,
    output logic [pgpc_pkg::CELL_AW-1:0]  o_grid_raddr,
    input  logic [pgpc_pkg::CHAR_W-1:0]   i_grid_rdata,
    output logic                          o_pair_we,
    output logic [pgpc_pkg::PAIR_AW-1:0]  o_pair_waddr,
    output logic [pgpc_pkg::CNT_W-1:0]    o_pair_wdata,
    output logic [pgpc_pkg::PAIR_AW-1:0]  o_pair_raddr,
    input  logic [pgpc_pkg::CNT_W-1:0]    i_pair_rdata
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PAIR = 4'd1;
    localparam logic [3:0] S_CH2  = 4'd2;
    localparam logic [3:0] S_CH3  = 4'd3;
    localparam logic [3:0] S_PRD  = 4'd4;
    localparam logic [3:0] S_PACC = 4'd5;
    localparam logic [3:0] S_WR   = 4'd6;
    localparam logic [3:0] S_NEXT = 4'd7;
    localparam logic [3:0] S_SRD  = 4'd8;
    localparam logic [3:0] S_SACC = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    localparam int SW = pgpc_pkg::SIDE_W;

    localparam logic signed [SW+2:0] S_ONE = (SW+3)'(1);

    logic [3:0]                 r_state, n_state;
    logic [SW-1:0]              r_nd, n_nd;
    logic [SW-1:0]              r_nr1, n_nr1;
    logic [SW-1:0]              r_nr2, n_nr2;
    logic [1:0]                 r_k, n_k;
    logic [pgpc_pkg::CNT_W-1:0] r_acc, n_acc;
    logic [pgpc_pkg::CHAR_W-1:0] r_cha, n_cha;

    logic signed [SW+2:0] s_last, s_nd, s_nr1, s_nr2, s_nc1, s_nc2;
    logic signed [SW+2:0] s_a, s_b, s_pr1, s_pc1, s_pr2, s_pc2;
    logic                 geo_ok, pred_ok, layer_end;
    logic [SW-1:0]        cell_r, cell_c;
    logic [SW:0]          side;
    logic [2*SW:0]        cell_lin;

    // Column coordinates of the pair on the layer under construction.
    assign s_last = $signed({3'b000, i_req.last});
    assign s_nd   = $signed({3'b000, r_nd});
    assign s_nr1  = $signed({3'b000, r_nr1});
    assign s_nr2  = $signed({3'b000, r_nr2});
    assign s_nc1  = s_nd - s_nr1;
    assign s_nc2  = (s_last <<< 1) - s_nd - s_nr2;

    assign geo_ok = (s_nc1 >= 0) && (s_nc1 <= s_last) && (s_nc2 >= 0)
                 && (s_nc2 <= s_last) && (s_nc1 <= s_nc2);

    // Predecessor pair on the previous layer for move code r_k.
    assign s_a   = $signed({{(SW+2){1'b0}}, r_k[1]});
    assign s_b   = $signed({{(SW+2){1'b0}}, r_k[0]});
    assign s_pr1 = s_nr1 - s_a;
    assign s_pc1 = s_nc1 - S_ONE + s_a;
    assign s_pr2 = s_nr2 + s_b;
    assign s_pc2 = s_nc2 + S_ONE - s_b;

    assign pred_ok = (s_pr1 >= 0) && (s_pc1 >= 0) && (s_pr2 <= s_last)
                  && (s_pc2 <= s_last) && (s_pc2 >= s_pc1);

    assign layer_end = (r_nd == '0) || ((r_nr1 == i_req.last) && (r_nr2 == i_req.last));

    // Raster address of the cell being fetched.
    always_comb begin
        if (r_state == S_CH2) begin
            cell_r = r_nr2;
            cell_c = s_nc2[SW-1:0];
        end else begin
            cell_r = r_nr1;
            cell_c = s_nc1[SW-1:0];
        end
    end

    assign side         = {1'b0, i_req.last} + 1'b1;
    assign cell_lin     = {{(SW+1){1'b0}}, cell_r} * {{SW{1'b0}}, side}
                        + {{(SW+1){1'b0}}, cell_c};
    assign o_grid_raddr = cell_lin[pgpc_pkg::CELL_AW-1:0];

    // Layer memory ports.
    assign o_pair_we    = (r_state == S_WR);
    assign o_pair_waddr = {r_nd[0], r_nr1, r_nr2};
    assign o_pair_wdata = r_acc;

    always_comb begin
        if (r_state == S_SRD) begin
            o_pair_raddr = {r_nd[0], r_nr1, r_nr1};
        end else begin
            o_pair_raddr = {~r_nd[0], s_pr1[SW-1:0], s_pr2[SW-1:0]};
        end
    end

    assign o_rsp.done  = (r_state == S_DONE);
    assign o_rsp.count = r_acc;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        n_nd    = r_nd;
        n_nr1   = r_nr1;
        n_nr2   = r_nr2;
        n_k     = r_k;
        n_acc   = r_acc;
        n_cha   = r_cha;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_nd    = '0;
                    n_nr1   = '0;
                    n_nr2   = i_req.last;
                    n_state = S_PAIR;
                end
            end
            S_PAIR: begin
                n_state = geo_ok ? S_CH2 : S_NEXT;
            end
            S_CH2: begin
                n_cha   = i_grid_rdata;
                n_state = S_CH3;
            end
            S_CH3: begin
                n_k = '0;
                if (i_grid_rdata != r_cha) begin
                    n_acc   = '0;
                    n_state = S_WR;
                end else if (r_nd == '0) begin
                    n_acc   = pgpc_pkg::CNT_W'(1);
                    n_state = S_WR;
                end else begin
                    n_acc   = '0;
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                if (pred_ok) begin
                    n_state = S_PACC;
                end else if (r_k == 2'd3) begin
                    n_state = S_WR;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_PACC: begin
                n_acc = pgpc_pkg::mod_add(r_acc, i_pair_rdata);
                if (r_k == 2'd3) begin
                    n_state = S_WR;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_PRD;
                end
            end
            S_WR: begin
                n_state = S_NEXT;
            end
            S_NEXT: begin
                if (layer_end) begin
                    if (r_nd == i_req.last) begin
                        n_nr1   = '0;
                        n_acc   = '0;
                        n_state = S_SRD;
                    end else begin
                        n_nd    = r_nd + 1'b1;
                        n_nr1   = '0;
                        n_nr2   = '0;
                        n_state = S_PAIR;
                    end
                end else if (r_nr2 != i_req.last) begin
                    n_nr2   = r_nr2 + 1'b1;
                    n_state = S_PAIR;
                end else begin
                    n_nr1   = r_nr1 + 1'b1;
                    n_nr2   = r_nr1 + 1'b1;
                    n_state = S_PAIR;
                end
            end
            S_SRD: begin
                n_state = S_SACC;
            end
            S_SACC: begin
                n_acc = pgpc_pkg::mod_add(r_acc, i_pair_rdata);
                if (r_nr1 == i_req.last) begin
                    n_state = S_DONE;
                end else begin
                    n_nr1   = r_nr1 + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_DONE: begin
                if (i_req.ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Loop indexes and data registers.
    always_ff @(posedge i_clk) begin
        r_nd  <= n_nd;
        r_nr1 <= n_nr1;
        r_nr2 <= n_nr2;
        r_k   <= n_k;
        r_acc <= n_acc;
        r_cha <= n_cha;
    end

endmodule

[design/palindromic_grid_path_counter.sv]
// A cell beat is stored in the cycle it is accepted; after the last cell the count walks
// n layers of n(n+1)/2 pair positions (the first layer has one), then sums the final
// layer and hands off the count.
// Throughput: one cell per cycle while loading; the layer memory port paced by the sequencer
// sets the count time, and the block takes no cells until the count is handed off.
// Reset (synchronous, active low) sets the size to 1, the load position and result to zero.
module palindromic_grid_path_counter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [pgpc_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [pgpc_pkg::CHAR_W-1:0]  i_cell_char,
    input  logic                         i_last_cell,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [pgpc_pkg::CNT_W-1:0]   o_path_count
);

    logic [pgpc_pkg::CFG_W-1:0]  r_grid_size;
    logic [pgpc_pkg::POS_W-1:0]  r_load_pos;
    logic                        r_busy;
    logic                        r_out_valid;
    logic [pgpc_pkg::CNT_W-1:0]  r_path_count;

    logic [pgpc_pkg::SIDE_W:0]   side;
    logic [pgpc_pkg::POS_W-1:0]  cells;
    logic                        in_take, store, result_take;
    pgpc_pkg::t_dp_req           dp_req;
    pgpc_pkg::t_dp_rsp           dp_rsp;

    logic [pgpc_pkg::CELL_AW-1:0] grid_raddr;
    logic [pgpc_pkg::CHAR_W-1:0]  grid_rdata;
    logic                         pair_we;
    logic [pgpc_pkg::PAIR_AW-1:0] pair_waddr, pair_raddr;
    logic [pgpc_pkg::CNT_W-1:0]   pair_wdata, pair_rdata;

    // Side length in use, clamped to the supported range.
    always_comb begin
        if (r_grid_size == '0) begin
            side = (pgpc_pkg::SIDE_W+1)'(1);
        end else if (r_grid_size > pgpc_pkg::CFG_W'(pgpc_pkg::MAX_SIDE)) begin
            side = (pgpc_pkg::SIDE_W+1)'(pgpc_pkg::MAX_SIDE);
        end else begin
            side = r_grid_size[pgpc_pkg::SIDE_W:0];
        end
    end

    assign cells = {{pgpc_pkg::SIDE_W{1'b0}}, side} * {{pgpc_pkg::SIDE_W{1'b0}}, side};

    // Input and output handshakes.
    assign o_stall     = r_busy;
    assign in_take     = i_valid && !r_busy;
    assign store       = in_take && (r_load_pos < cells);
    assign result_take = dp_rsp.done && !r_out_valid;

    assign dp_req.start = in_take && i_last_cell;
    assign dp_req.ack   = result_take;
    assign dp_req.last  = pgpc_pkg::SIDE_W'(side - 1'b1);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= pgpc_pkg::CFG_W'(1);
        end else if (i_cfg_wr_en) begin
            r_grid_size <= i_cfg_wr_data;
        end
    end

    // Load position, busy flag and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos   <= '0;
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_path_count <= '0;
        end else begin
            if (in_take && i_last_cell) begin
                r_load_pos <= '0;
                r_busy     <= 1'b1;
            end else if (store) begin
                r_load_pos <= r_load_pos + 1'b1;
            end
            if (result_take) begin
                r_busy       <= 1'b0;
                r_out_valid  <= 1'b1;
                r_path_count <= dp_rsp.count;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_path_count = r_path_count;

    // Grid character store.
    pgpc_ram #(
        .WIDTH (pgpc_pkg::CHAR_W),
        .DEPTH (pgpc_pkg::MAX_SIDE * pgpc_pkg::MAX_SIDE)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (store),
        .i_waddr (r_load_pos[pgpc_pkg::CELL_AW-1:0]),
        .i_wdata (i_cell_char),
        .i_raddr (grid_raddr),
        .o_rdata (grid_rdata)
    );

    // Two alternating pair layers.
    pgpc_ram #(
        .WIDTH (pgpc_pkg::CNT_W),
        .DEPTH (2 * pgpc_pkg::MAX_SIDE * pgpc_pkg::MAX_SIDE)
    ) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (pair_we),
        .i_waddr (pair_waddr),
        .i_wdata (pair_wdata),
        .i_raddr (pair_raddr),
        .o_rdata (pair_rdata)
    );

    pgpc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (dp_req),
        .o_rsp        (dp_rsp),
        .o_grid_raddr (grid_raddr),
        .i_grid_rdata (grid_rdata),
        .o_pair_we    (pair_we),
        .o_pair_waddr (pair_waddr),
        .o_pair_wdata (pair_wdata),
        .o_pair_raddr (pair_raddr),
        .i_pair_rdata (pair_rdata)
    );

endmodule

[design/pgpc_chk.sv]
// Port level checks of the palindromic grid path counter and their binding.
module pgpc_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       i_last_cell,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [pgpc_pkg::CNT_W-1:0] o_path_count
);

    // A result beat held back stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped while stalled");

    // Every count is a reduced residue.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_path_count < pgpc_pkg::PATH_MOD))
        else $error("path count not reduced");

    // The last cell starts a count, which blocks further cells.
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last_cell |=> o_stall)
        else $error("input not stalled during count");

    // A result only appears at the end of a count.
    a_result_after_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without count");

endmodule

bind palindromic_grid_path_counter pgpc_chk u_pgpc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_last_cell  (i_last_cell),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_path_count (o_path_count)
);
